/* rtl/core/key_debounce_event_fifo_assert.svh */
// Assertion macros shared by the key debounce event FIFO RTL
`ifndef KEY_DEBOUNCE_EVENT_FIFO_ASSERT_SVH
`define KEY_DEBOUNCE_EVENT_FIFO_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define KDF_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define KDF_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);
`else
`define KDF_ASSERT(name, prop, msg)
`define KDF_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

/* rtl/core/kdf_pkg.sv */
// Shared types and constants of the key debounce event FIFO
package kdf_pkg;

   localparam int PIN_BITS  = 17;
   localparam int CODE_W    = 6;
   localparam int CNT_W     = 4;
   localparam int LP_W      = 16;
   localparam int RT_W      = 8;
   localparam int CSR_IDX_W = 1;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_POP  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT     = 1'b1;

   localparam logic [LP_W-1:0] LP_RESET = 16'd100;
   localparam logic [RT_W-1:0] RT_RESET = 8'd0;

   typedef struct packed {
      logic                op;
      logic [PIN_BITS-1:0] pins_raw;
   } req_type;

   typedef struct packed {
      logic [CODE_W-1:0]   key_code;
      logic [PIN_BITS-1:0] pressed_mask;
   } rsp_type;

   typedef struct packed {
      logic              valid;
      logic [CODE_W-1:0] code;
   } push_type;

   typedef struct packed {
      logic [CNT_W-1:0] cnt;
      logic [LP_W-1:0]  hold;
      logic [RT_W-1:0]  rep;
   } key_state_type;

endpackage

/* rtl/core/kdf_event_fifo.sv */
// Ring buffer of key event codes with a registered pop read
module kdf_event_fifo #(
   parameter int FIFO_DEPTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  kdf_pkg::push_type         push,
   input  logic                      pop_req,
   output logic [kdf_pkg::CODE_W-1:0] pop_code
);
   import kdf_pkg::*;

   localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam logic [PW-1:0] LAST_SLOT = PW'(FIFO_DEPTH - 1);

   logic [CODE_W-1:0] fifo_mem [FIFO_DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic              hit_ff, hit_in;
   logic [CODE_W-1:0] rd_data_ff;
   logic              pop_hit;

   assign pop_hit = pop_req && (rd_ptr_ff != wr_ptr_ff);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      hit_in    = pop_hit;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop_hit) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + PW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         hit_ff    <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         hit_ff    <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         fifo_mem[wr_ptr_ff] <= push.code;
      end
      if (pop_hit) begin
         rd_data_ff <= fifo_mem[rd_ptr_ff];
      end
   end

   assign pop_code = hit_ff ? rd_data_ff : '0;

endmodule

/* rtl/core/kdf_key_scan.sv */
// Serial key walker: debounce, long-press and repeat over a key state memory
module kdf_key_scan #(
   parameter int NUM_KEYS     = 17,
   parameter int FILTER_TICKS = 5
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [kdf_pkg::PIN_BITS-1:0] pins,
   input  logic [kdf_pkg::LP_W-1:0]     long_press_ticks,
   input  logic [kdf_pkg::RT_W-1:0]     repeat_ticks,
   output kdf_pkg::push_type            push,
   output logic                        done,
   output logic [kdf_pkg::PIN_BITS-1:0] pressed_mask
);
   import kdf_pkg::*;

   localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
   localparam logic [KW-1:0]    LAST_KEY = KW'(NUM_KEYS - 1);
   localparam logic [CNT_W-1:0] F_CNT    = CNT_W'(FILTER_TICKS);
   localparam logic [CNT_W-1:0] F2_CNT   = CNT_W'(2 * FILTER_TICKS);
   localparam logic [CNT_W-1:0] F_HALF   = CNT_W'(FILTER_TICKS / 2);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_READ  = 2'd1;
   localparam logic [1:0] S_EVAL  = 2'd2;
   localparam logic [1:0] S_PUSH2 = 2'd3;

   key_state_type key_mem [NUM_KEYS];
   key_state_type rd_ff;

   logic [1:0]          state_ff, state_in;
   logic [KW-1:0]       key_ff, key_in;
   logic [NUM_KEYS-1:0] kp_ff, kp_in;
   logic [NUM_KEYS-1:0] init_ff, init_in;
   logic [CODE_W-1:0]   second_ff, second_in;

   key_state_type       cur, nxt;
   logic                mem_we;
   logic [PIN_BITS-1:0] down_shift;
   logic                key_down, pressed, pressed_nxt;
   logic [CODE_W-1:0]   code_base, code_press, code_release, code_long;
   logic [LP_W-1:0]     hold_inc;
   logic [RT_W-1:0]     rep_inc;
   logic                eva_v, evb_v;
   logic [CODE_W-1:0]   eva_code, evb_code;
   logic                last_key;

   assign down_shift   = (~pins) >> key_ff;
   assign key_down     = down_shift[0];
   assign pressed      = kp_ff[key_ff];
   assign code_base    = (CODE_W'(key_ff) << 1) + CODE_W'(key_ff);
   assign code_press   = code_base + CODE_W'(1);
   assign code_release = code_base + CODE_W'(2);
   assign code_long    = code_base + CODE_W'(3);
   assign last_key     = (key_ff == LAST_KEY);

   always_comb begin
      if (init_ff[key_ff]) begin
         cur = rd_ff;
      end else begin
         cur.cnt  = F_HALF;
         cur.hold = '0;
         cur.rep  = '0;
      end
   end

   always_comb begin
      nxt         = cur;
      pressed_nxt = pressed;
      hold_inc    = cur.hold + LP_W'(1);
      rep_inc     = cur.rep + RT_W'(1);
      eva_v       = 1'b0;
      eva_code    = code_press;
      evb_v       = 1'b0;
      evb_code    = code_press;
      if (key_down) begin
         if (cur.cnt < F_CNT) begin
            nxt.cnt = F_CNT;
         end else if (cur.cnt < F2_CNT) begin
            nxt.cnt = cur.cnt + CNT_W'(1);
         end else begin
            if (!pressed) begin
               pressed_nxt = 1'b1;
               eva_v       = 1'b1;
            end
            if (long_press_ticks != '0) begin
               if (cur.hold < long_press_ticks) begin
                  nxt.hold = hold_inc;
                  if (hold_inc == long_press_ticks) begin
                     evb_v    = 1'b1;
                     evb_code = code_long;
                  end
               end else if (repeat_ticks != '0) begin
                  if (rep_inc >= repeat_ticks) begin
                     nxt.rep = '0;
                     evb_v   = 1'b1;
                  end else begin
                     nxt.rep = rep_inc;
                  end
               end
            end
         end
      end else begin
         if (cur.cnt > F_CNT) begin
            nxt.cnt = F_CNT;
         end else if (cur.cnt != '0) begin
            nxt.cnt = cur.cnt - CNT_W'(1);
         end else if (pressed) begin
            pressed_nxt = 1'b0;
            eva_v       = 1'b1;
            eva_code    = code_release;
         end
         nxt.hold = '0;
         nxt.rep  = '0;
      end
   end

   always_comb begin
      state_in   = state_ff;
      key_in     = key_ff;
      kp_in      = kp_ff;
      init_in    = init_ff;
      second_in  = second_ff;
      mem_we     = 1'b0;
      push.valid = 1'b0;
      push.code  = eva_code;
      done       = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               key_in   = '0;
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            mem_we          = 1'b1;
            kp_in[key_ff]   = pressed_nxt;
            init_in[key_ff] = 1'b1;
            push.valid      = eva_v || evb_v;
            push.code       = eva_v ? eva_code : evb_code;
            if (eva_v && evb_v) begin
               second_in = evb_code;
               state_in  = S_PUSH2;
            end else if (last_key) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end else begin
               key_in   = key_ff + KW'(1);
               state_in = S_READ;
            end
         end
         S_PUSH2: begin
            push.valid = 1'b1;
            push.code  = second_ff;
            if (last_key) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end else begin
               key_in   = key_ff + KW'(1);
               state_in = S_READ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         key_ff   <= '0;
         kp_ff    <= '0;
         init_ff  <= '0;
      end else begin
         state_ff <= state_in;
         key_ff   <= key_in;
         kp_ff    <= kp_in;
         init_ff  <= init_in;
      end
   end

   always_ff @(posedge clock) begin
      second_ff <= second_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem[key_ff] <= nxt;
      end
      if (state_ff == S_READ) begin
         rd_ff <= key_mem[key_ff];
      end
   end

   assign pressed_mask = PIN_BITS'(kp_ff);

endmodule

/* rtl/core/key_debounce_event_fifo.sv */
// Key debounce scanner with a ring FIFO of press, release, long and repeat codes
// A scan tick request walks the keys one at a time through a single-port key state
// memory: each key passes a read state, then an evaluate and write-back state, and
// a second push state when it queues two codes (press and long press on the same
// tick). A pop request waits on the registered read of the event buffer before its
// response. The next request is taken as soon as the engine is free, even while the
// last response waits.
// Codes: 3i+1 press or repeat, 3i+2 release, 3i+3 long press, 0 for an empty pop or
// a tick. The event buffer has no full check; overflow overwrites the oldest codes.
`include "key_debounce_event_fifo_assert.svh"
module key_debounce_event_fifo #(
   parameter int NUM_KEYS     = 17,
   parameter int FILTER_TICKS = 5,
   parameter int FIFO_DEPTH   = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  kdf_pkg::req_type             req_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output kdf_pkg::rsp_type             rsp_payload,
   input  logic                         csr_write,
   input  logic [kdf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [kdf_pkg::LP_W-1:0]      csr_wdata
);
   import kdf_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_POP  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [PIN_BITS-1:0] pins_ff, pins_in;
   logic [LP_W-1:0]     lp_ff, lp_in;
   logic [RT_W-1:0]     rt_ff, rt_in;
   logic [CODE_W-1:0]   code_ff, code_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                accept;
   logic                scan_start, scan_done, pop_req;
   push_type            push;
   logic [CODE_W-1:0]   pop_code;
   logic [PIN_BITS-1:0] mask;

   assign req_ready   = (state_ff == ST_IDLE);
   assign accept      = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   kdf_key_scan #(
      .NUM_KEYS     (NUM_KEYS),
      .FILTER_TICKS (FILTER_TICKS)
   ) u_scan (
      .clock            (clock),
      .reset            (reset),
      .start            (scan_start),
      .pins             (pins_ff),
      .long_press_ticks (lp_ff),
      .repeat_ticks     (rt_ff),
      .push             (push),
      .done             (scan_done),
      .pressed_mask     (mask)
   );

   kdf_event_fifo #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .pop_req  (pop_req),
      .pop_code (pop_code)
   );

   always_comb begin
      lp_in = lp_ff;
      rt_in = rt_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_LONG_PRESS: lp_in = csr_wdata;
            CSR_REPEAT:     rt_in = csr_wdata[RT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      pins_in      = pins_ff;
      code_in      = code_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      scan_start   = 1'b0;
      pop_req      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pins_in = req_payload.pins_raw;
               code_in = '0;
               if (req_payload.op == OP_POP) begin
                  pop_req  = 1'b1;
                  state_in = ST_POP;
               end else begin
                  scan_start = 1'b1;
                  state_in   = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_DONE;
            end
         end
         ST_POP: begin
            code_in  = pop_code;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in        = 1'b1;
               rsp_in.key_code     = code_ff;
               rsp_in.pressed_mask = mask;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         lp_ff        <= LP_RESET;
         rt_ff        <= RT_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         lp_ff        <= lp_in;
         rt_ff        <= rt_in;
      end
   end

   always_ff @(posedge clock) begin
      pins_ff <= pins_in;
      code_ff <= code_in;
      rsp_ff  <= rsp_in;
   end

   `KDF_ASSERT(a_push_in_scan, push.valid |-> (state_ff == ST_SCAN), "code pushed outside a scan")
   `KDF_ASSERT(a_done_in_scan, scan_done |-> (state_ff == ST_SCAN), "scan done while not scanning")
   `KDF_ASSERT_ALWAYS(a_tick_no_code, $past(scan_done) |-> (code_ff == '0), "tick carries a code")

endmodule

/* tb/key_event_checker.sv */
// Response predictor and comparator for the key debounce event FIFO
module key_event_checker #(
   parameter int NUM_KEYS     = 17,
   parameter int FILTER_TICKS = 5,
   parameter int FIFO_DEPTH   = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  kdf_pkg::req_type              req_payload,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  kdf_pkg::rsp_type              rsp_payload,
   input  logic                          csr_write,
   input  logic [kdf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [kdf_pkg::LP_W-1:0]      csr_wdata,
   output int                            mismatches,
   output int                            outstanding
);
   import kdf_pkg::*;

   logic [CNT_W-1:0]  filter_cnt [NUM_KEYS];
   logic              key_down   [NUM_KEYS];
   logic [LP_W-1:0]   hold_cnt   [NUM_KEYS];
   logic [RT_W-1:0]   repeat_cnt [NUM_KEYS];
   logic [CODE_W-1:0] code_ring  [FIFO_DEPTH];
   int                rd_ptr;
   int                wr_ptr;
   logic [LP_W-1:0]   long_press_ticks;
   logic [RT_W-1:0]   repeat_ticks;
   rsp_type           awaited_rsp [$];

   function automatic void queue_code(input int code);
      code_ring[wr_ptr] = code[CODE_W-1:0];
      wr_ptr = (wr_ptr + 1) % FIFO_DEPTH;
   endfunction

   function automatic void scan_key(input int k, input bit down);
      int cnt;
      int r;
      cnt = filter_cnt[k];
      if (down) begin
         if (cnt < FILTER_TICKS) begin
            cnt = FILTER_TICKS;
         end else if (cnt < 2 * FILTER_TICKS) begin
            cnt++;
         end else begin
            if (!key_down[k]) begin
               key_down[k] = 1'b1;
               queue_code(3 * k + 1);
            end
            if (long_press_ticks != 0) begin
               if (hold_cnt[k] < long_press_ticks) begin
                  hold_cnt[k] = hold_cnt[k] + 1'b1;
                  if (hold_cnt[k] == long_press_ticks)
                     queue_code(3 * k + 3);
               end else if (repeat_ticks != 0) begin
                  r = (repeat_cnt[k] + 1) % 256;
                  if (r >= repeat_ticks) begin
                     r = 0;
                     queue_code(3 * k + 1);
                  end
                  repeat_cnt[k] = r[RT_W-1:0];
               end
            end
         end
      end else begin
         if (cnt > FILTER_TICKS) begin
            cnt = FILTER_TICKS;
         end else if (cnt != 0) begin
            cnt--;
         end else if (key_down[k]) begin
            key_down[k] = 1'b0;
            queue_code(3 * k + 2);
         end
         hold_cnt[k]   = '0;
         repeat_cnt[k] = '0;
      end
      filter_cnt[k] = cnt[CNT_W-1:0];
   endfunction

   function automatic rsp_type next_rsp(input req_type rq);
      rsp_type rs;
      bit      down;
      rs = '0;
      if (rq.op == OP_TICK) begin
         for (int k = 0; k < NUM_KEYS; k++) begin
            down = (k < PIN_BITS) ? !rq.pins_raw[k] : 1'b0;
            scan_key(k, down);
         end
      end else if (rd_ptr != wr_ptr) begin
         rs.key_code = code_ring[rd_ptr];
         rd_ptr = (rd_ptr + 1) % FIFO_DEPTH;
      end
      for (int k = 0; k < NUM_KEYS && k < PIN_BITS; k++)
         rs.pressed_mask[k] = key_down[k];
      return rs;
   endfunction

   always @(posedge clock) begin
      rsp_type seen;
      rsp_type want;
      if (reset) begin
         for (int k = 0; k < NUM_KEYS; k++) begin
            filter_cnt[k] = CNT_W'(FILTER_TICKS / 2);
            key_down[k]   = 1'b0;
            hold_cnt[k]   = '0;
            repeat_cnt[k] = '0;
         end
         rd_ptr           = 0;
         wr_ptr           = 0;
         long_press_ticks = LP_RESET;
         repeat_ticks     = RT_RESET;
         mismatches       = 0;
         awaited_rsp.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen = rsp_payload;
            if (awaited_rsp.size() == 0) begin
               mismatches++;
               $display("%0t: response with none expected, got code %0d mask %05h",
                        $time, seen.key_code, seen.pressed_mask);
            end else begin
               want = awaited_rsp.pop_front();
               if (seen.key_code !== want.key_code) begin
                  mismatches++;
                  $display("%0t: key_code mismatch, expected %0d, got %0d",
                           $time, want.key_code, seen.key_code);
               end
               if (seen.pressed_mask !== want.pressed_mask) begin
                  mismatches++;
                  $display("%0t: pressed_mask mismatch, expected %05h, got %05h",
                           $time, want.pressed_mask, seen.pressed_mask);
               end
            end
         end
         if (csr_write) begin
            case (csr_index)
               CSR_LONG_PRESS: long_press_ticks = csr_wdata;
               CSR_REPEAT:     repeat_ticks = csr_wdata[RT_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            awaited_rsp.push_back(next_rsp(req_payload));
      end
      outstanding = awaited_rsp.size();
   end

endmodule

/* tb/tb_top.sv */
// Stimulus, register phases and verdict for the key debounce event FIFO
module tb_top;
   import kdf_pkg::*;

   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 60;
   localparam int CYCLE_LIMIT     = 800000;
   localparam int FIRST_ITEMS     = 200;
   localparam int PHASE_ITEMS     = 130;
   localparam int IDLE_PCT        = 28;

   localparam logic [LP_W-1:0] LP_PLAN [7] = '{16'd4, 16'd0, 16'd65535, 16'd1,
                                               16'd30, 16'd6, 16'd0};
   localparam logic [RT_W-1:0] RT_PLAN [7] = '{8'd2, 8'd255, 8'd255, 8'd1,
                                               8'd0, 8'd3, 8'd0};

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_type              req_payload;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_type              rsp_payload;
   logic                 csr_write;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [LP_W-1:0]      csr_wdata;

   int                   mismatches;
   int                   outstanding;
   int                   cycles;
   bit                   calm;
   int                   stall_asks;
   int                   stall_done;
   logic [PIN_BITS-1:0]  held_pins;

   key_debounce_event_fifo dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   key_event_checker key_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // hold off the response side on request, otherwise stall at random unless calm
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_asks != stall_done) begin
            stall_done = stall_asks;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end
         rsp_ready <= calm || ($urandom_range(99, 0) >= IDLE_PCT);
      end
   end

   task automatic send_req(input logic op, input logic [PIN_BITS-1:0] pins);
      while (!calm && $urandom_range(99, 0) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{op: op, pins_raw: pins};
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic tick(input logic [PIN_BITS-1:0] pins);
      send_req(OP_TICK, pins);
   endtask

   task automatic pop();
      send_req(OP_POP, PIN_BITS'($urandom()));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (outstanding != 0)
         @(negedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [LP_W-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_regs(input logic [LP_W-1:0] lp, input logic [RT_W-1:0] rt);
      logic [7:0] junk;
      junk = 8'($urandom_range(255, 0));
      wait_idle();
      repeat (4) @(negedge clock);
      write_csr(CSR_LONG_PRESS, lp);
      write_csr(CSR_REPEAT, {junk, rt});
   endtask

   // pop, or keep most keys steady for long holds; toggle, reshuffle and bounce now and then
   task automatic random_item();
      logic [PIN_BITS-1:0] pins;
      int                  roll;
      roll = $urandom_range(999, 0);
      if (roll < 380) begin
         pop();
      end else begin
         if (roll < 395)
            held_pins = PIN_BITS'($urandom());
         else if (roll < 455)
            held_pins[$urandom_range(PIN_BITS-1, 0)] ^= 1'b1;
         pins = held_pins;
         if ($urandom_range(99, 0) < 5)
            pins[$urandom_range(PIN_BITS-1, 0)] ^= 1'b1;
         tick(pins);
      end
   endtask

   initial begin
      logic [LP_W-1:0] lp;
      logic [RT_W-1:0] rt;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_write   = 1'b0;
      csr_index   = CSR_LONG_PRESS;
      csr_wdata   = '0;
      held_pins   = '1;
      calm        = 1'b0;
      stall_asks  = 0;
      stall_done  = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      pop();
      tick('1);
      repeat (7) tick('0);
      repeat (3) pop();
      tick(17'h15555);
      tick('0);
      repeat (7) tick('1);
      repeat (2) pop();

      for (int i = 0; i < FIRST_ITEMS; i++)
         random_item();

      for (int p = 0; p < 7; p++) begin
         lp = (p == 6) ? LP_W'($urandom_range(40, 1)) : LP_PLAN[p];
         rt = (p == 6) ? RT_W'($urandom_range(8, 0)) : RT_PLAN[p];
         set_regs(lp, rt);
         calm = (p == 1);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (p == 0 && i == 40)
               stall_asks++;
            if (p == 0 && i == 90)
               wait_idle();
            random_item();
         end
      end
      calm = 1'b0;

      wait_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/kdf_pkg.sv
rtl/core/kdf_event_fifo.sv
rtl/core/kdf_key_scan.sv
rtl/core/key_debounce_event_fifo.sv
tb/key_event_checker.sv
tb/tb_top.sv
